// ===== hw/rtl/tet_to_hex_adjoint_deposit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TET_TO_HEX_ADJOINT_DEPOSIT_ASSERT_SVH
`define TET_TO_HEX_ADJOINT_DEPOSIT_ASSERT_SVH

// Check a property on every rising edge, skip while in reset.
`define TTHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define TTHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ===== hw/rtl/tthd_pkg.sv =====
package tthd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 64;
  localparam int NUM_COEFFS = 19;
  localparam int NUM_NODES  = 8;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ONE_I      = 1 << FRAC_BITS;
  localparam int ACC_W      = 52;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 64;
  localparam int L_W        = FRAC_BITS;
  localparam int H_W        = FRAC_BITS + 1;
  localparam int STEP_W     = 6;
  localparam int NODE_W     = 3;
  localparam int CIDX_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_X    = 3'd3,
    CFG_INV_Y    = 3'd4,
    CFG_INV_Z    = 3'd5
  } cfg_reg_t;

  // Request actions
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_DEPOSIT = 1'b1;

  // Coefficient slots
  localparam int CF_F0  = 0;
  localparam int CF_F1  = 1;
  localparam int CF_F2  = 2;
  localparam int CF_F3  = 3;
  localparam int CF_V0X = 4;
  localparam int CF_V0Y = 5;
  localparam int CF_V0Z = 6;
  localparam int CF_J00 = 7;
  localparam int CF_X   = 16;
  localparam int CF_Y   = 17;
  localparam int CF_W   = 18;

  typedef logic [STEP_W-1:0] step_t;

  // Multiply sequence, one product per step
  localparam step_t ST_LX  = 6'd0;
  localparam step_t ST_LY  = 6'd1;
  localparam step_t ST_LZ  = 6'd2;
  localparam step_t ST_C0  = 6'd3;
  localparam step_t ST_C1  = 6'd4;
  localparam step_t ST_C2  = 6'd5;
  localparam step_t ST_C3  = 6'd6;
  localparam step_t ST_R00 = 6'd7;
  localparam step_t ST_R01 = 6'd8;
  localparam step_t ST_R02 = 6'd9;
  localparam step_t ST_R10 = 6'd10;
  localparam step_t ST_R11 = 6'd11;
  localparam step_t ST_R12 = 6'd12;
  localparam step_t ST_R20 = 6'd13;
  localparam step_t ST_R21 = 6'd14;
  localparam step_t ST_R22 = 6'd15;
  localparam step_t ST_V0  = 6'd16;
  localparam step_t ST_V1  = 6'd17;
  localparam step_t ST_V2  = 6'd18;
  localparam step_t ST_V3  = 6'd19;
  localparam step_t ST_H0  = 6'd20;
  localparam step_t ST_Q   = 6'd21;
  localparam step_t ST_H1  = 6'd22;
  localparam step_t ST_H2  = 6'd23;
  localparam step_t ST_H3  = 6'd24;
  localparam step_t ST_H4  = 6'd25;
  localparam step_t ST_H5  = 6'd26;
  localparam step_t ST_H6  = 6'd27;
  localparam step_t ST_H7  = 6'd28;
  localparam step_t ST_D0  = 6'd29;
  localparam step_t ST_D1  = 6'd30;
  localparam step_t ST_D2  = 6'd31;
  localparam step_t ST_D3  = 6'd32;
  localparam step_t ST_D4  = 6'd33;
  localparam step_t ST_D5  = 6'd34;
  localparam step_t ST_D6  = 6'd35;
  localparam step_t ST_D7  = 6'd36;
  localparam step_t ST_END = 6'd37;
  // Each Hn, for n from 1 to 7, sits n steps after this base
  localparam step_t ST_HBASE = 6'd21;

  typedef struct packed {
    logic                    action;
    logic [CIDX_W-1:0]       coeff_index;
    logic signed [31:0]      coeff_value;
    logic signed [31:0]      point_z;
    logic                    last_point;
  } in_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]       node_index;
    logic signed [63:0]      node_sum;
    logic                    overflow;
    logic                    last_node;
  } out_res_t;

  typedef struct packed {
    logic              load;
    logic              capture;
    logic              step_en;
    step_t             step;
    logic              emit;
    logic [NODE_W-1:0] node;
    logic              ovf;
  } ctl_cmd_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = ACC_W'(-32'sh7FFF_FFFF) - ACC_W'(1);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

  // Saturating 64-bit add
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    end else begin
      sat_add64 = 64'(s);
    end
  endfunction

endpackage

// ===== hw/rtl/tthd_ctrl.sv =====
module tthd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tthd_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  tthd_pkg::step_t                 step_r, step_nxt;
  logic [tthd_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            last_r, last_nxt;
  logic [tthd_pkg::NODE_W-1:0]     node_r, node_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign in_acc    = in_valid && in_ready;

  // Sequence loads, sample steps and the node flush
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    node_nxt      = node_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.step      = step_r;
    cmd.node      = node_r;
    cmd.ovf       = ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action == tthd_pkg::ACT_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            last_nxt    = in_last;
            node_nxt    = '0;
            if (cnt_r >= tthd_pkg::CNT_W'(tthd_pkg::MAX_POINTS)) begin
              // Over the limit: flag and skip accumulation
              ovf_nxt = 1'b1;
              if (in_last) begin
                state_nxt = S_EMIT;
              end
            end else begin
              cnt_nxt   = cnt_r + tthd_pkg::CNT_W'(1);
              step_nxt  = '0;
              state_nxt = S_CALC;
            end
          end
        end
      end
      S_CALC: begin
        if (step_r == tthd_pkg::ST_END) begin
          // Last product written back this cycle
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end else begin
          cmd.step_en = 1'b1;
          step_nxt    = step_r + tthd_pkg::STEP_W'(1);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (node_r == tthd_pkg::NODE_W'(tthd_pkg::NUM_NODES - 1)) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            node_nxt = node_r + tthd_pkg::NODE_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      node_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      node_r      <= node_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/tthd_datapath.sv =====
module tthd_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tthd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tthd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  tthd_pkg::in_req_t                    in_data,
  input  tthd_pkg::ctl_cmd_t                   cmd,
  output tthd_pkg::out_res_t                   out_data
);

  localparam int F  = tthd_pkg::FRAC_BITS;
  localparam int AW = tthd_pkg::ACC_W;
  localparam int MW = tthd_pkg::MUL_W;
  localparam int HW = tthd_pkg::H_W;

  // Coefficients, configuration and intermediate values
  logic signed [31:0]           coef_r [tthd_pkg::NUM_COEFFS];
  logic signed [31:0]           org_r  [3];
  logic [30:0]                  inv_r  [3];
  logic signed [31:0]           z_r;
  logic [tthd_pkg::L_W-1:0]     lx_r, ly_r, lz_r;
  logic [HW-1:0]                c_r [4];
  logic [HW-1:0]                h_r [tthd_pkg::NUM_NODES];
  logic signed [AW-1:0]         acc_r;
  logic signed [31:0]           r_r [3];
  logic signed [31:0]           v_r, q_r;
  logic signed [63:0]           node_r [tthd_pkg::NUM_NODES];
  logic signed [tthd_pkg::PROD_W-1:0] prod_r;
  logic                         wb_en_r;
  tthd_pkg::step_t              wb_step_r;
  tthd_pkg::out_res_t           out_r;

  logic [31:0]                  dx, dy, dz;
  logic signed [32:0]           ex, ey, ez;
  logic signed [31:0]           o0, o1, o2, f0;
  logic signed [AW-1:0]         f0_sum;
  logic [HW-1:0]                omlx, omly, omlz;
  logic signed [MW-1:0]         opa, opb;
  logic [tthd_pkg::NODE_W-1:0]  hn, hn_wb, dn_wb, rd_idx;
  logic signed [AW-1:0]         term, acc_base, acc_sum;
  logic                         wb_first;
  logic signed [63:0]           node_rd;

  // Grid offsets, low word only feeds the fraction
  assign dx = coef_r[tthd_pkg::CF_X] - org_r[0];
  assign dy = coef_r[tthd_pkg::CF_Y] - org_r[1];
  assign dz = z_r - org_r[2];

  // Offsets from vertex 0, clamped
  assign ex = 33'(coef_r[tthd_pkg::CF_X]) - 33'(coef_r[tthd_pkg::CF_V0X]);
  assign ey = 33'(coef_r[tthd_pkg::CF_Y]) - 33'(coef_r[tthd_pkg::CF_V0Y]);
  assign ez = 33'(z_r) - 33'(coef_r[tthd_pkg::CF_V0Z]);
  assign o0 = tthd_pkg::sat32(AW'(ex));
  assign o1 = tthd_pkg::sat32(AW'(ey));
  assign o2 = tthd_pkg::sat32(AW'(ez));

  // First barycentric weight
  assign f0_sum = AW'(tthd_pkg::ONE_I) - AW'(r_r[0]) - AW'(r_r[1]) - AW'(r_r[2]);
  assign f0     = tthd_pkg::sat32(f0_sum);

  assign omlx = HW'(tthd_pkg::ONE_I) - HW'(lx_r);
  assign omly = HW'(tthd_pkg::ONE_I) - HW'(ly_r);
  assign omlz = HW'(tthd_pkg::ONE_I) - HW'(lz_r);

  assign hn    = (cmd.step == tthd_pkg::ST_H0) ? '0 :
                 tthd_pkg::NODE_W'(cmd.step - tthd_pkg::ST_HBASE);
  assign hn_wb = (wb_step_r == tthd_pkg::ST_H0) ? '0 :
                 tthd_pkg::NODE_W'(wb_step_r - tthd_pkg::ST_HBASE);
  assign dn_wb = tthd_pkg::NODE_W'(wb_step_r - tthd_pkg::ST_D0);

  // Select multiplier operands for the current step
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.step)
      tthd_pkg::ST_LX: begin opa = 33'($signed(dx)); opb = 33'(inv_r[0]); end
      tthd_pkg::ST_LY: begin opa = 33'($signed(dy)); opb = 33'(inv_r[1]); end
      tthd_pkg::ST_LZ: begin opa = 33'($signed(dz)); opb = 33'(inv_r[2]); end
      tthd_pkg::ST_C0: begin opa = 33'(omlx); opb = 33'(omly); end
      tthd_pkg::ST_C1: begin opa = 33'(lx_r); opb = 33'(omly); end
      tthd_pkg::ST_C2: begin opa = 33'(lx_r); opb = 33'(ly_r); end
      tthd_pkg::ST_C3: begin opa = 33'(omlx); opb = 33'(ly_r); end
      tthd_pkg::ST_R00: begin opa = 33'(coef_r[tthd_pkg::CF_J00]);     opb = 33'(o0); end
      tthd_pkg::ST_R01: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 1]); opb = 33'(o1); end
      tthd_pkg::ST_R02: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 2]); opb = 33'(o2); end
      tthd_pkg::ST_R10: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 3]); opb = 33'(o0); end
      tthd_pkg::ST_R11: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 4]); opb = 33'(o1); end
      tthd_pkg::ST_R12: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 5]); opb = 33'(o2); end
      tthd_pkg::ST_R20: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 6]); opb = 33'(o0); end
      tthd_pkg::ST_R21: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 7]); opb = 33'(o1); end
      tthd_pkg::ST_R22: begin opa = 33'(coef_r[tthd_pkg::CF_J00 + 8]); opb = 33'(o2); end
      tthd_pkg::ST_V0: begin opa = 33'(r_r[0]); opb = 33'(coef_r[tthd_pkg::CF_F1]); end
      tthd_pkg::ST_V1: begin opa = 33'(r_r[1]); opb = 33'(coef_r[tthd_pkg::CF_F2]); end
      tthd_pkg::ST_V2: begin opa = 33'(r_r[2]); opb = 33'(coef_r[tthd_pkg::CF_F3]); end
      tthd_pkg::ST_V3: begin opa = 33'(f0);     opb = 33'(coef_r[tthd_pkg::CF_F0]); end
      tthd_pkg::ST_Q:  begin opa = 33'(v_r);    opb = 33'(coef_r[tthd_pkg::CF_W]);  end
      tthd_pkg::ST_H0, tthd_pkg::ST_H1, tthd_pkg::ST_H2, tthd_pkg::ST_H3,
      tthd_pkg::ST_H4, tthd_pkg::ST_H5, tthd_pkg::ST_H6, tthd_pkg::ST_H7: begin
        opa = 33'(c_r[hn[1:0]]);
        opb = hn[2] ? 33'(lz_r) : 33'(omlz);
      end
      tthd_pkg::ST_D0, tthd_pkg::ST_D1, tthd_pkg::ST_D2, tthd_pkg::ST_D3,
      tthd_pkg::ST_D4, tthd_pkg::ST_D5, tthd_pkg::ST_D6, tthd_pkg::ST_D7: begin
        opa = 33'(q_r);
        opb = 33'(h_r[tthd_pkg::NODE_W'(cmd.step - tthd_pkg::ST_D0)]);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Running sum of shifted products
  always_comb begin
    wb_first = (wb_step_r == tthd_pkg::ST_R00) || (wb_step_r == tthd_pkg::ST_R10) ||
               (wb_step_r == tthd_pkg::ST_R20) || (wb_step_r == tthd_pkg::ST_V0);
    term     = AW'(prod_r >>> F);
    acc_base = wb_first ? '0 : acc_r;
    acc_sum  = acc_base + term;
  end

  // One accumulator read port, shared by flush and deposit
  assign rd_idx  = cmd.emit ? cmd.node : dn_wb;
  assign node_rd = node_r[rd_idx];

  // Multiply, write back, load coefficients and capture the output
  always_ff @(posedge clk) begin
    prod_r <= tthd_pkg::PROD_W'(opa) * tthd_pkg::PROD_W'(opb);

    if (cmd.load && (in_data.coeff_index < tthd_pkg::CIDX_W'(tthd_pkg::NUM_COEFFS))) begin
      coef_r[in_data.coeff_index] <= in_data.coeff_value;
    end
    if (cmd.capture) begin
      z_r <= in_data.point_z;
    end

    if (wb_en_r) begin
      case (wb_step_r)
        tthd_pkg::ST_LX: lx_r <= prod_r[2*F-1:F];
        tthd_pkg::ST_LY: ly_r <= prod_r[2*F-1:F];
        tthd_pkg::ST_LZ: lz_r <= prod_r[2*F-1:F];
        tthd_pkg::ST_C0: c_r[0] <= prod_r[2*F:F];
        tthd_pkg::ST_C1: c_r[1] <= prod_r[2*F:F];
        tthd_pkg::ST_C2: c_r[2] <= prod_r[2*F:F];
        tthd_pkg::ST_C3: c_r[3] <= prod_r[2*F:F];
        tthd_pkg::ST_R00, tthd_pkg::ST_R01, tthd_pkg::ST_R10, tthd_pkg::ST_R11,
        tthd_pkg::ST_R20, tthd_pkg::ST_R21, tthd_pkg::ST_V0, tthd_pkg::ST_V1,
        tthd_pkg::ST_V2: acc_r <= acc_sum;
        tthd_pkg::ST_R02: r_r[0] <= tthd_pkg::sat32(acc_sum);
        tthd_pkg::ST_R12: r_r[1] <= tthd_pkg::sat32(acc_sum);
        tthd_pkg::ST_R22: r_r[2] <= tthd_pkg::sat32(acc_sum);
        tthd_pkg::ST_V3:  v_r    <= tthd_pkg::sat32(acc_sum);
        tthd_pkg::ST_Q:   q_r    <= tthd_pkg::sat32(term);
        tthd_pkg::ST_H0, tthd_pkg::ST_H1, tthd_pkg::ST_H2, tthd_pkg::ST_H3,
        tthd_pkg::ST_H4, tthd_pkg::ST_H5, tthd_pkg::ST_H6, tthd_pkg::ST_H7:
          h_r[hn_wb] <= prod_r[2*F:F];
        default: begin
        end
      endcase
    end

    if (cmd.emit) begin
      out_r.node_index <= cmd.node;
      out_r.node_sum   <= cmd.ovf ? 64'sd0 : node_rd;
      out_r.overflow   <= cmd.ovf;
      out_r.last_node  <= (cmd.node == tthd_pkg::NODE_W'(tthd_pkg::NUM_NODES - 1));
    end
  end

  // Node accumulators: deposit, clear on flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tthd_pkg::NUM_NODES; i++) begin
        node_r[i] <= '0;
      end
      wb_en_r   <= 1'b0;
      wb_step_r <= '0;
    end else begin
      wb_en_r   <= cmd.step_en;
      wb_step_r <= cmd.step;
      if (cmd.emit) begin
        node_r[cmd.node] <= '0;
      end else if (wb_en_r && (wb_step_r >= tthd_pkg::ST_D0) &&
                   (wb_step_r <= tthd_pkg::ST_D7)) begin
        node_r[dn_wb] <= tthd_pkg::sat_add64(node_rd, prod_r);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      inv_r[0] <= 31'(tthd_pkg::ONE_I);
      inv_r[1] <= 31'(tthd_pkg::ONE_I);
      inv_r[2] <= 31'(tthd_pkg::ONE_I);
    end else if (cfg_we) begin
      case (cfg_addr)
        tthd_pkg::CFG_ORIGIN_X: org_r[0] <= cfg_wdata;
        tthd_pkg::CFG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        tthd_pkg::CFG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        tthd_pkg::CFG_INV_X:    inv_r[0] <= cfg_wdata[30:0];
        tthd_pkg::CFG_INV_Y:    inv_r[1] <= cfg_wdata[30:0];
        tthd_pkg::CFG_INV_Z:    inv_r[2] <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/tet_to_hex_adjoint_deposit.sv =====
// Hex8 deposit of a tet4 barycentric interpolant for one column of z samples.
// A coefficient load (action 0) leaves the block ready for the next request. A
// deposit request (action 1) steps a single 33x33 signed multiplier through 37
// products (grid fractions, trilinear factors, inverse Jacobian, interpolation,
// weight, eight node deposits), each written back the cycle after it is formed.
// A sample past the point limit is not accumulated and only raises the overflow
// flag. A request marked last then flushes the eight node sums, one per cycle
// as the output is taken, and clears the column; no request is taken during
// the computation or the flush of nodes 0 to 6.
module tet_to_hex_adjoint_deposit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tthd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [tthd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tthd_pkg::in_req_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tthd_pkg::out_res_t                   out_data
);

  tthd_pkg::ctl_cmd_t cmd;

  tthd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_last   (in_data.last_point),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  tthd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/tthd_checker.sv =====
`include "tet_to_hex_adjoint_deposit_assert.svh"

module tthd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input tthd_pkg::out_res_t out_data
);

  // Hold a stalled result
  `TTHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // Flag the end of the flush on node seven only
  `TTHD_ASSERT(a_last_node, clk, rst_n, out_valid |-> (out_data.last_node == (out_data.node_index == 3'd7)), "last_node does not match node seven")

  // Drop sums of an overflowed column
  `TTHD_ASSERT(a_ovf_zero, clk, rst_n, (out_valid && out_data.overflow) |-> (out_data.node_sum == 64'sd0), "overflow with nonzero sum")

  // Block new requests in the middle of a flush
  `TTHD_ASSERT(a_flush_busy, clk, rst_n, (out_valid && !out_data.last_node) |-> !in_ready, "request taken during flush")

  // Advance through the nodes in order
  `TTHD_ASSERT_NEXT(a_node_order, clk, rst_n, out_valid && out_ready && !out_data.last_node, out_valid && (out_data.node_index == $past(out_data.node_index) + 3'd1), "flush skipped a node")

endmodule

bind tet_to_hex_adjoint_deposit tthd_checker u_tthd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/tb_tet_to_hex_adjoint_deposit.sv =====
`default_nettype none

module tb_tet_to_hex_adjoint_deposit;
  timeunit 1ns;
  timeprecision 1ps;

  import tthd_pkg::*;

  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD     = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_data;

  tet_to_hex_adjoint_deposit DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // Shadow state of the column deposit
  longint coef[NUM_COEFFS];
  longint node_acc[NUM_NODES];
  int     samples_taken;
  bit     too_many;
  longint origin[3];
  longint inv_step[3];

  out_res_t node_sums_due[$];
  int mismatches = 0;
  int received = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_clamp64(longint a, longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'h7FFF_FFFF_FFFF_FFFF;
    if (a < 0 && b < 0 && s >= 0) return 64'h8000_0000_0000_0000;
    return s;
  endfunction

  // Floor fraction of the grid position along one axis
  function automatic longint grid_frac(longint p, int axis);
    longint g;
    g = (p - origin[axis]) * inv_step[axis];
    return longint'(g[2*FRAC_BITS-1:FRAC_BITS]);
  endfunction

  function automatic void accumulate_sample(longint z);
    longint one, lx, ly, lz, cxy[4], o[3], r[3], f0, v, q, zf, h, s;
    one = longint'(ONE_I);
    lx = grid_frac(coef[CF_X], 0);
    ly = grid_frac(coef[CF_Y], 1);
    lz = grid_frac(z, 2);
    cxy[0] = ((one - lx) * (one - ly)) >>> FRAC_BITS;
    cxy[1] = (lx * (one - ly)) >>> FRAC_BITS;
    cxy[2] = (lx * ly) >>> FRAC_BITS;
    cxy[3] = ((one - lx) * ly) >>> FRAC_BITS;
    o[0] = clamp32(coef[CF_X] - coef[CF_V0X]);
    o[1] = clamp32(coef[CF_Y] - coef[CF_V0Y]);
    o[2] = clamp32(z - coef[CF_V0Z]);
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += (coef[CF_J00 + 3*i + j] * o[j]) >>> FRAC_BITS;
      r[i] = clamp32(s);
    end
    f0 = clamp32(one - r[0] - r[1] - r[2]);
    v = clamp32(((f0 * coef[CF_F0]) >>> FRAC_BITS) + ((r[0] * coef[CF_F1]) >>> FRAC_BITS)
              + ((r[1] * coef[CF_F2]) >>> FRAC_BITS) + ((r[2] * coef[CF_F3]) >>> FRAC_BITS));
    q = clamp32((v * coef[CF_W]) >>> FRAC_BITS);
    for (int n = 0; n < NUM_NODES; n++) begin
      zf = (n < 4) ? (one - lz) : lz;
      h = (cxy[n % 4] * zf) >>> FRAC_BITS;
      node_acc[n] = add_clamp64(node_acc[n], q * h);
    end
  endfunction

  // Advance the shadow state by one accepted request; push node sums on flush
  function automatic void predict_request(in_req_t r, bit typed_zero);
    out_res_t res;
    if (r.action == ACT_LOAD) begin
      if (r.coeff_index < NUM_COEFFS) coef[r.coeff_index] = longint'(r.coeff_value);
      return;
    end
    if (samples_taken >= MAX_POINTS) too_many = 1'b1;
    else begin
      samples_taken++;
      if (!too_many) accumulate_sample(longint'(r.point_z));
    end
    if (!r.last_point) return;
    for (int n = 0; n < NUM_NODES; n++) begin
      res.node_index = NODE_W'(n);
      res.node_sum   = (too_many || typed_zero) ? 64'sd0 : node_acc[n];
      res.overflow   = too_many;
      res.last_node  = (n == NUM_NODES - 1);
      node_sums_due.push_back(res);
      node_acc[n] = 0;
    end
    samples_taken = 0;
    too_many = 1'b0;
  endfunction

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(in_req_t r, bit typed_zero);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    predict_request(r, typed_zero);
  endtask

  // Drop valid, let every flush drain and any open sample finish
  task automatic drain_block();
    in_valid <= 1'b0;
    while (node_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx <= CFG_ORIGIN_Z) origin[idx] = longint'(signed'(val));
    else inv_step[idx - CFG_INV_X] = longint'(val[30:0]);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0: return v;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(signed'(v[19:0]));
    endcase
  endfunction

  function automatic in_req_t make_req(logic act, int idx, logic [31:0] val,
                                       logic [31:0] z, logic last);
    in_req_t r;
    r.action = act;
    r.coeff_index = CIDX_W'(idx);
    r.coeff_value = val;
    r.point_z = z;
    r.last_point = last;
    return r;
  endfunction

  // Random columns: a few coefficient reloads, then samples ending in a flush
  task automatic run_columns(int n_items, int long_column);
    int sent, loads, pts, idx;
    logic [31:0] junk;
    sent = 0;
    while (sent < n_items || long_column > 0) begin
      loads = $urandom_range(0, 3);
      for (int k = 0; k < loads; k++) begin
        idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 18);
        junk = $urandom();
        send_request(make_req(ACT_LOAD, idx, rand_value(), junk, junk[0]), 1'b0);
        sent++;
      end
      pts = (long_column > 0) ? long_column : $urandom_range(1, 4);
      long_column = 0;
      for (int k = 0; k < pts; k++) begin
        junk = $urandom();
        send_request(make_req(ACT_DEPOSIT, $urandom_range(0, 31), junk,
                              rand_value(), k == pts - 1), 1'b0);
        sent++;
      end
    end
  endtask

  typedef struct {
    logic        act;
    int          idx;
    logic [31:0] val;
    logic [31:0] z;
    logic        last;
    bit          zero_flush;
  } dir_row_t;

  dir_row_t dir_tab[25];

  // Stimulus
  initial begin
    for (int i = 0; i < NUM_COEFFS; i++) coef[i] = 0;
    for (int i = 0; i < NUM_NODES; i++) node_acc[i] = 0;
    samples_taken = 0;
    too_many = 1'b0;
    for (int i = 0; i < 3; i++) begin
      origin[i] = 0;
      inv_step[i] = longint'(ONE_I);
    end
    dir_tab = '{
      '{ACT_LOAD, 0,  32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 1,  32'h8000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 2,  32'h0002_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 3,  32'hFFFF_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 4,  32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 5,  32'h0001_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 6,  32'h8000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 7,  32'h0001_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 8,  32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 9,  32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 10, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 11, 32'h0001_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 12, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 13, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 14, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 15, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 16, 32'h0001_8000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 17, 32'hFFFF_4000, 32'h0, 1'b0, 1'b0},
      '{ACT_LOAD, 18, 32'h0000_0000, 32'h0, 1'b0, 1'b0},
      // zero weight: every node sum is zero
      '{ACT_DEPOSIT, 0, 32'h0, 32'h0003_2000, 1'b1, 1'b1},
      // out-of-range slots and load-time z/last are ignored
      '{ACT_LOAD, 31, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{ACT_LOAD, 19, 32'h1234_5678, 32'h8000_0000, 1'b1, 1'b0},
      '{ACT_LOAD, 18, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0},
      '{ACT_DEPOSIT, 31, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0},
      '{ACT_DEPOSIT, 0, 32'h0, 32'h7FFF_FFFF, 1'b1, 1'b0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i])
      send_request(make_req(dir_tab[i].act, dir_tab[i].idx, dir_tab[i].val,
                            dir_tab[i].z, dir_tab[i].last), dir_tab[i].zero_flush);
    run_columns(35, 0);
    for (int p = 0; p < 3; p++) begin
      drain_block();
      case (p)
        0: begin
          for (int a = CFG_ORIGIN_X; a <= CFG_ORIGIN_Z; a++)
            write_reg(cfg_reg_t'(a), rand_value());
          for (int a = CFG_INV_X; a <= CFG_INV_Z; a++)
            write_reg(cfg_reg_t'(a), {1'b0, 31'($urandom_range(1, 32'h0004_0000))});
        end
        1: begin
          for (int a = CFG_ORIGIN_X; a <= CFG_ORIGIN_Z; a++)
            write_reg(cfg_reg_t'(a), 32'h8000_0000);
          for (int a = CFG_INV_X; a <= CFG_INV_Z; a++)
            write_reg(cfg_reg_t'(a), 32'h7FFF_FFFF);
        end
        default: begin
          for (int a = CFG_ORIGIN_X; a <= CFG_ORIGIN_Z; a++)
            write_reg(cfg_reg_t'(a), 32'h7FFF_FFFF);
          for (int a = CFG_INV_X; a <= CFG_INV_Z; a++)
            write_reg(cfg_reg_t'(a), 32'h0000_0001);
        end
      endcase
      // in the first pass only, one column runs past the sample limit
      run_columns(35, (p == 0) ? MAX_POINTS + 2 : 0);
    end
    in_valid <= 1'b0;
    while (node_sums_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the block
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(0, 19);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (received == 20) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each taken node sum with the oldest one due
  always @(posedge clk) begin
    out_res_t e;
    if (rst_n && out_valid && out_ready) begin
      received++;
      if (node_sums_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected node sum: node %0d sum %0d",
                                       out_data.node_index, out_data.node_sum);
      end else begin
        e = node_sums_due.pop_front();
        if (out_data.node_index !== e.node_index || out_data.node_sum !== e.node_sum ||
            out_data.overflow !== e.overflow || out_data.last_node !== e.last_node) begin
          mismatches++;
          if (mismatches <= 10)
            $display("node mismatch: exp node %0d sum %0d ovf %0b last %0b, got %0d %0d %0b %0b",
                     e.node_index, e.node_sum, e.overflow, e.last_node, out_data.node_index,
                     out_data.node_sum, out_data.overflow, out_data.last_node);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tthd_pkg.sv
hw/rtl/tthd_ctrl.sv
hw/rtl/tthd_datapath.sv
hw/rtl/tet_to_hex_adjoint_deposit.sv
hw/rtl/tthd_checker.sv
dv/tb_tet_to_hex_adjoint_deposit.sv
